[sv/knn_velocity_interpolator_defines.svh]
// assertion macros shared by the knn velocity interpolator rtl
// no dependencies
`ifndef KNN_VELOCITY_INTERPOLATOR_DEFINES_SVH
`define KNN_VELOCITY_INTERPOLATOR_DEFINES_SVH

// assertion disabled during reset, clocked on clk_i
`define KVI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication form
`define KVI_ASSERT_IMP(lbl, ante, cons, msg) \
  `KVI_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[sv/kvi_pkg.sv]
// shared types and constants for the knn velocity interpolator
// no dependencies
package kvi_pkg;

  localparam int unsigned NumAnchors    = 64;
  localparam int unsigned MaxNeighbours = 8;
  localparam int unsigned AIdxW         = $clog2(NumAnchors);
  localparam int unsigned SelW          = $clog2(MaxNeighbours);
  localparam int unsigned D2W           = 25;
  localparam int unsigned DistW         = 21;
  localparam int unsigned WW            = 22;
  localparam int unsigned SumW          = 42;
  localparam int unsigned WsumW         = 26;

  typedef enum logic [1:0] {
    CfgMaxDist  = 2'd0,
    CfgNumNeigh = 2'd1,
    CfgAnchCnt  = 2'd2
  } cfg_idx_e;

  localparam logic CmdLoad  = 1'b0;
  localparam logic CmdQuery = 1'b1;

  typedef struct packed {
    logic [0:0]  cmd;
    logic [5:0]  anchor_index;
    logic [11:0] pos_x;
    logic [11:0] pos_y;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
  } req_t;

  typedef struct packed {
    logic signed [15:0] out_vel_x;
    logic signed [15:0] out_vel_y;
    logic [3:0]  used_count;
  } rsp_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [12:0] data;
  } cfg_t;

  // request to the shared divider/sqrt unit
  typedef struct packed {
    logic        start;
    logic        is_sqrt;
    logic [47:0] num;
    logic [25:0] den;
  } op_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [47:0] res;
  } op_rsp_t;

endpackage

[sv/kvi_if.sv]
// valid/ready channel interfaces for the knn velocity interpolator
// depends on kvi_pkg
interface kvi_req_if;
  kvi_pkg::req_t data;
  logic valid;
  logic ready;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kvi_rsp_if;
  kvi_pkg::rsp_t data;
  logic valid;
  logic ready;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kvi_cfg_if;
  kvi_pkg::cfg_t data;
  logic valid;
  logic ready;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/kvi_ram.sv]
// generic single port ram with registered read
// no dependencies
module kvi_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

[sv/kvi_divsqrt.sv]
// shared iterative unit: restoring divide (48/26) or integer square root (48 bit)
// depends on kvi_pkg; one result bit per cycle
module kvi_divsqrt (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kvi_pkg::op_req_t  req_i,
  output kvi_pkg::op_rsp_t  rsp_o
);
  import kvi_pkg::*;

  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d, sq_q, sq_d;
  logic [47:0] x_q, x_d, q_q, q_d;
  logic [49:0] rem_q, rem_d;
  logic [25:0] den_q, den_d;
  logic [49:0] trial;
  logic [49:0] rem_sh;

  always_comb begin
    cnt_d = cnt_q; busy_d = busy_q; done_d = 1'b0; sq_d = sq_q;
    x_d = x_q; q_d = q_q; rem_d = rem_q; den_d = den_q;
    rem_sh = '0; trial = '0;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1; sq_d = req_i.is_sqrt; x_d = req_i.num; den_d = req_i.den;
      q_d = '0; rem_d = '0;
      cnt_d = req_i.is_sqrt ? 6'd24 : 6'd48;
    end else if (busy_q) begin
      if (sq_q) begin
        // digit-by-digit root: bring down two bits
        rem_sh = {rem_q[47:0], x_q[47:46]};
        trial  = {q_q[47:0], 2'b01};
        x_d    = {x_q[45:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_d = rem_sh - trial;
          q_d   = {q_q[46:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          q_d   = {q_q[46:0], 1'b0};
        end
      end else begin
        rem_sh = {rem_q[48:0], x_q[47]};
        trial  = {24'd0, den_q};
        x_d    = {x_q[46:0], 1'b0};
        if (rem_sh >= trial) begin
          rem_d = rem_sh - trial;
          q_d   = {q_q[46:0], 1'b1};
        end else begin
          rem_d = rem_sh;
          q_d   = {q_q[46:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0; sq_q <= 1'b0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d; sq_q <= sq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; q_q <= q_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.res  = q_q;
endmodule

[sv/knn_velocity_interpolator.sv]
// top level of the knn velocity interpolator
// depends on kvi_pkg, kvi_if, kvi_ram, kvi_divsqrt and the defines header
`include "knn_velocity_interpolator_defines.svh"

// A load request writes one anchor entry when it is accepted and gives no
// response. A query request scans anchors 0..anchor_count-1 at one per cycle
// through the anchor ram (one read port, registered), keeping a sorted list of
// up to num_neighbours best squared distances. A shared iterative unit then
// takes the square roots and weight divides, one after another, and finally
// divides the two weighted sums. The nearest kept anchor always has weight
// one, so it needs no divide. A query with nothing kept goes straight from
// the scan to its response. The block takes no request while a query runs
// or its response waits. Configuration writes are accepted at any time and
// apply to the next query.
module knn_velocity_interpolator (
  input  logic     clk_i,
  input  logic     rst_ni,
  kvi_req_if.sink  req_i,
  kvi_cfg_if.sink  cfg_i,
  kvi_rsp_if.source rsp_o
);
  import kvi_pkg::*;

  typedef enum logic [8:0] {
    StIdle  = 9'b000000001,
    StScan  = 9'b000000010,
    StSqrt  = 9'b000000100,
    StWDiv  = 9'b000001000,
    StRead  = 9'b000010000,
    StMac   = 9'b000100000,
    StMean  = 9'b001000000,
    StDivW  = 9'b010000000,
    StResp  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [12:0] max_dist_q;
  logic [3:0]  num_neigh_q;
  logic [6:0]  anch_cnt_q;

  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q  <= 13'd8191;
      num_neigh_q <= 4'd4;
      anch_cnt_q  <= 7'd0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        CfgMaxDist:  max_dist_q  <= cfg_i.data.data;
        CfgNumNeigh: num_neigh_q <= cfg_i.data.data[3:0];
        CfgAnchCnt:  anch_cnt_q  <= cfg_i.data.data[6:0];
        default: ;
      endcase
    end
  end

  // anchor ram: px, py, vx, vy packed in one word
  logic             ram_we;
  logic [AIdxW-1:0] ram_addr;
  logic [55:0]      ram_wdata, ram_rdata;

  kvi_ram #(.Width(56), .Depth(NumAnchors)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // shared divide / square root unit
  op_req_t op_req;
  op_rsp_t op_rsp;
  kvi_divsqrt u_ds (.clk_i(clk_i), .rst_ni(rst_ni), .req_i(op_req), .rsp_o(op_rsp));

  // working registers
  logic [11:0]      qx_q, qy_q;
  logic [3:0]       k_q;
  logic [6:0]       cnt_q;
  logic [25:0]      lim_q;
  logic [6:0]       scan_q;      // address issued
  logic             rd_vld_q;    // ram data valid for entry scan_idx_q
  logic [AIdxW-1:0] scan_idx_q;
  logic [3:0]       n_q;
  logic [D2W-1:0]   sel_d2_q  [MaxNeighbours];
  logic [AIdxW-1:0] sel_idx_q [MaxNeighbours];
  logic [DistW-1:0] d0_q;
  logic [SelW:0]    j_q;
  logic [WW-1:0]    w_q;
  logic [WsumW-1:0] wsum_q;
  logic signed [SumW-1:0] sx_q, sy_q;
  logic             op_go_q, ysel_q;
  logic [15:0]      resx_q;
  rsp_t             rsp_q;
  logic             rsp_vld_q;

  // distance of the entry that the ram returned
  logic signed [12:0] dx, dy;
  logic [D2W-1:0]     d2;
  logic [25:0]        dxx, dyy;
  always_comb begin
    dx  = $signed({1'b0, ram_rdata[55:44]}) - $signed({1'b0, qx_q});
    dy  = $signed({1'b0, ram_rdata[43:32]}) - $signed({1'b0, qy_q});
    dxx = 26'($signed(dx) * $signed(dx));
    dyy = 26'($signed(dy) * $signed(dy));
    d2  = D2W'(dxx + dyy);
  end

  // insertion: entry j shifts down when the new d2 beats it strictly
  logic [MaxNeighbours-1:0] beat;
  logic [MaxNeighbours-1:0] occ;
  always_comb begin
    for (int i = 0; i < MaxNeighbours; i++) begin
      occ[i]  = (4'(i) < n_q);
      beat[i] = occ[i] && (d2 < sel_d2_q[i]);
    end
  end

  logic [3:0] pos;
  always_comb begin
    pos = n_q;
    for (int i = 0; i < MaxNeighbours; i++) begin
      if (beat[i] && 4'(i) < pos) pos = 4'(i);
    end
  end

  logic ins;
  assign ins = rd_vld_q && ({1'b0, d2} <= lim_q) && (pos < k_q);

  // rounded mean magnitude and signed saturation
  logic [SumW-1:0] mag;
  logic            neg;
  logic signed [SumW-1:0] cur_sum;
  assign cur_sum = ysel_q ? sy_q : sx_q;
  assign neg = cur_sum[SumW-1];
  assign mag = neg ? SumW'(-cur_sum) : cur_sum;

  function automatic logic [15:0] sat16(input logic [47:0] q, input logic ng);
    logic [15:0] r;
    if (ng) r = (q > 48'd32768) ? 16'h8000 : 16'(-q);
    else    r = (q > 48'd32767) ? 16'h7fff : q[15:0];
    return r;
  endfunction

  logic [D2W-1:0] jd2;
  assign jd2 = sel_d2_q[j_q[SelW-1:0]];

  assign req_i.ready = state_q == StIdle && !rsp_vld_q;
  assign rsp_o.valid = rsp_vld_q;
  assign rsp_o.data  = rsp_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = scan_q[AIdxW-1:0];
    ram_wdata = {req_i.data.pos_x, req_i.data.pos_y, req_i.data.vel_x, req_i.data.vel_y};
    op_req    = '0;
    if (state_q == StIdle) begin
      ram_addr = req_i.data.anchor_index;
      ram_we   = req_i.valid && req_i.ready && req_i.data.cmd == CmdLoad;
    end else if (state_q == StRead || state_q == StMac) begin
      ram_addr = sel_idx_q[j_q[SelW-1:0]];
    end
    if (op_go_q) begin
      op_req.start = 1'b1;
      unique case (state_q)
        StSqrt: begin
          op_req.is_sqrt = 1'b1;
          op_req.num     = {7'd0, jd2, 16'd0};
        end
        StWDiv: begin
          op_req.num = 48'(op_rsp.res) << 8;
          op_req.den = 26'(d0_q);
        end
        default: begin
          op_req.num = 48'(mag + SumW'(wsum_q >> 1));
          op_req.den = wsum_q;
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (req_i.valid && req_i.ready && req_i.data.cmd == CmdQuery) state_d = StScan;
      StScan: if (!rd_vld_q && (scan_q >= cnt_q || k_q == 4'd0)) begin
        state_d = (n_q == 4'd0) ? StResp : StSqrt;
      end
      // nearest anchor and zero nearest distance both give weight one
      StSqrt: if (op_rsp.done) state_d = (j_q == '0 || d0_q == '0) ? StRead : StWDiv;
      StWDiv: if (op_rsp.done) state_d = StRead;
      StRead: state_d = StMac;
      StMac:  state_d = (4'(j_q) + 4'd1 >= n_q) ? StMean : StSqrt;
      StMean: state_d = StDivW;
      StDivW: if (op_rsp.done) state_d = ysel_q ? StResp : StDivW;
      StResp: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      rsp_vld_q <= 1'b0;
      rd_vld_q  <= 1'b0;
      op_go_q   <= 1'b0;
      n_q       <= '0;
      ysel_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      op_go_q <= 1'b0;
      if (rsp_vld_q && rsp_o.ready) rsp_vld_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          rd_vld_q <= 1'b0;
          if (state_d == StScan) begin
            n_q <= '0;
            ysel_q <= 1'b0;
          end
        end
        StScan: begin
          rd_vld_q <= (scan_q < cnt_q) && k_q != 4'd0;
          if (ins && n_q < k_q) n_q <= n_q + 4'd1;
          if (state_d == StSqrt) op_go_q <= 1'b1;
        end
        StSqrt: if (op_rsp.done && state_d != StRead) op_go_q <= 1'b1;
        StMac: if (state_d == StSqrt) op_go_q <= 1'b1;
        StMean: op_go_q <= 1'b1;
        StDivW: if (op_rsp.done && !ysel_q) begin
          ysel_q  <= 1'b1;
          op_go_q <= 1'b1;
        end
        StResp: rsp_vld_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      StIdle: begin
        qx_q   <= req_i.data.pos_x;
        qy_q   <= req_i.data.pos_y;
        k_q    <= (num_neigh_q > 4'(MaxNeighbours)) ? 4'(MaxNeighbours) : num_neigh_q;
        cnt_q  <= (anch_cnt_q > 7'(NumAnchors)) ? 7'(NumAnchors) : anch_cnt_q;
        lim_q  <= 26'(max_dist_q * max_dist_q);
        scan_q <= '0;
        j_q    <= '0;
        wsum_q <= '0;
        sx_q   <= '0;
        sy_q   <= '0;
      end
      StScan: begin
        if (scan_q < cnt_q) scan_q <= scan_q + 7'd1;
        scan_idx_q <= scan_q[AIdxW-1:0];
        if (ins) begin
          for (int i = MaxNeighbours - 1; i > 0; i--) begin
            if (4'(i) > pos) begin
              sel_d2_q[i]  <= sel_d2_q[i-1];
              sel_idx_q[i] <= sel_idx_q[i-1];
            end
          end
          sel_d2_q[pos[SelW-1:0]]  <= d2;
          sel_idx_q[pos[SelW-1:0]] <= scan_idx_q;
        end
        rsp_q <= '0;
      end
      StSqrt: if (op_rsp.done) begin
        if (j_q == '0) d0_q <= op_rsp.res[DistW-1:0];
        if (state_d == StRead) w_q <= WW'(256);
      end
      StWDiv: if (op_rsp.done) w_q <= op_rsp.res[WW-1:0];
      StMac: begin
        wsum_q <= wsum_q + WsumW'(w_q);
        sx_q   <= sx_q + SumW'($signed({1'b0, w_q}) * $signed(ram_rdata[31:16]));
        sy_q   <= sy_q + SumW'($signed({1'b0, w_q}) * $signed(ram_rdata[15:0]));
        j_q    <= j_q + (SelW+1)'(1);
      end
      StDivW: if (op_rsp.done) begin
        if (!ysel_q) resx_q <= sat16(op_rsp.res, neg);
        else begin
          rsp_q.out_vel_x  <= resx_q;
          rsp_q.out_vel_y  <= sat16(op_rsp.res, neg);
          rsp_q.used_count <= n_q;
        end
      end
      default: ;
    endcase
  end

  `KVI_ASSERT_IMP(a_no_req_busy, state_q != StIdle, !req_i.ready, "request taken while busy")
  `KVI_ASSERT_IMP(a_count_bound, state_q != StIdle, n_q <= k_q, "neighbour count above limit")
  `KVI_ASSERT_IMP(a_resp_after, $rose(rsp_vld_q), $past(state_q) == StResp, "stray response")
  `KVI_ASSERT_IMP(a_op_idle, op_go_q, !op_rsp.busy, "shared unit started while busy")

endmodule

[verif/tb_top.sv]
// self-checking testbench for the knn velocity interpolator
// depends on kvi_pkg, the kvi channel interfaces and the block's rtl
`timescale 1ns / 1ps

module tb_top;
  import kvi_pkg::*;

  localparam int IdleLimit  = 6000;  // cycles with no handshake at all
  localparam int DrainWait  = 40;    // loads give no response, let them settle
  localparam int LongHold   = 500;   // receiver hold-off for the pressure phase

  logic clk_i;
  logic rst_ni;

  kvi_req_if req_ch ();
  kvi_cfg_if cfg_ch ();
  kvi_rsp_if rsp_ch ();

  knn_velocity_interpolator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch.sink),
    .cfg_i  (cfg_ch.sink),
    .rsp_o  (rsp_ch.source)
  );

  // anchor table and register copies used for prediction
  logic [11:0]        tbl_px [NumAnchors];
  logic [11:0]        tbl_py [NumAnchors];
  logic signed [15:0] tbl_vx [NumAnchors];
  logic signed [15:0] tbl_vy [NumAnchors];
  logic [12:0]        reg_max_dist;
  logic [3:0]         reg_num_neigh;
  logic [6:0]         reg_anch_cnt;

  req_t pending_reqs [$];
  rsp_t expected_vel [$];
  int   err_cnt;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   rsp_hold;
  bit   req_fired;
  int   quiet_cycles;

  // cluster used to place anchors and query points near each other
  int   cl_x, cl_y, cl_r;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    err_cnt++;
  endtask

  // floor(sqrt(x)) by bitwise trial
  function automatic longint unsigned root_floor(input longint unsigned x);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 23; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] round_sat(input longint num, input longint den);
    longint mag;
    longint q;
    mag = (num < 0) ? -num : num;
    q = (mag + den / 2) / den;
    if (num < 0) return (q > 32768) ? 16'sh8000 : 16'(-q);
    return (q > 32767) ? 16'sh7fff : 16'(q);
  endfunction

  // weighted mean of the nearest anchors' velocities at the query point
  function automatic rsp_t interp_velocity(input req_t q);
    longint unsigned best_d2 [MaxNeighbours];
    int              best_ix [MaxNeighbours];
    int              k, cnt, n, pos, j;
    longint unsigned lim, d2, d0, w, wsum;
    longint          dx, dy, sx, sy;
    rsp_t            r;
    k    = (reg_num_neigh > MaxNeighbours) ? MaxNeighbours : reg_num_neigh;
    cnt  = (reg_anch_cnt > NumAnchors) ? NumAnchors : reg_anch_cnt;
    lim  = longint'(reg_max_dist) * longint'(reg_max_dist);
    n    = 0;
    for (int i = 0; i < cnt && k > 0; i++) begin
      dx = longint'(tbl_px[i]) - longint'(q.pos_x);
      dy = longint'(tbl_py[i]) - longint'(q.pos_y);
      d2 = dx * dx + dy * dy;
      if (d2 > lim) continue;
      pos = n;
      while (pos > 0 && d2 < best_d2[pos-1]) pos--;
      if (pos >= k) continue;
      for (j = (n < k) ? n : k - 1; j > pos; j--) begin
        best_d2[j] = best_d2[j-1];
        best_ix[j] = best_ix[j-1];
      end
      best_d2[pos] = d2;
      best_ix[pos] = i;
      if (n < k) n++;
    end
    r = '0;
    if (n == 0) return r;
    d0 = root_floor(best_d2[0] << 16);
    wsum = 0;
    sx = 0;
    sy = 0;
    for (j = 0; j < n; j++) begin
      w = (d0 == 0) ? 256 : (root_floor(best_d2[j] << 16) << 8) / d0;
      wsum += w;
      sx += longint'(w) * longint'(tbl_vx[best_ix[j]]);
      sy += longint'(w) * longint'(tbl_vy[best_ix[j]]);
    end
    r.out_vel_x  = round_sat(sx, wsum);
    r.out_vel_y  = round_sat(sy, wsum);
    r.used_count = 4'(n);
    return r;
  endfunction

  // request driver: inputs change on the falling edge
  always @(negedge clk_i) begin
    if (!req_ch.valid || req_fired) begin
      req_fired = 1'b0;
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req_ch.valid <= 1'b1;
        req_ch.data  <= pending_reqs[0];
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // response ready, with the long hold-off counted here
  always @(negedge clk_i) begin
    if (rsp_hold > 0) begin
      rsp_hold--;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: requests feed the predictor, responses are checked in order
  always @(posedge clk_i) begin
    req_t acc;
    rsp_t want;
    if (rst_ni && req_ch.valid && req_ch.ready) begin
      acc = pending_reqs.pop_front();
      req_fired = 1'b1;
      if (acc.cmd == CmdLoad) begin
        tbl_px[acc.anchor_index] = acc.pos_x;
        tbl_py[acc.anchor_index] = acc.pos_y;
        tbl_vx[acc.anchor_index] = acc.vel_x;
        tbl_vy[acc.anchor_index] = acc.vel_y;
      end else begin
        expected_vel.insert(expected_vel.size(), interp_velocity(acc));
      end
    end
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_vel.size() == 0) begin
        report_mismatch("unexpected response count", 1, 0);
      end else begin
        want = expected_vel.pop_front();
        if (rsp_ch.data.out_vel_x !== want.out_vel_x)
          report_mismatch("out_vel_x", rsp_ch.data.out_vel_x, want.out_vel_x);
        if (rsp_ch.data.out_vel_y !== want.out_vel_y)
          report_mismatch("out_vel_y", rsp_ch.data.out_vel_y, want.out_vel_y);
        if (rsp_ch.data.used_count !== want.used_count)
          report_mismatch("used_count", rsp_ch.data.used_count, want.used_count);
      end
    end
  end

  // watchdog on handshake activity
  always @(posedge clk_i) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input int value);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data.index <= idx;
    cfg_ch.data.data  <= 13'(value);
    do @(posedge clk_i); while (!(cfg_ch.valid && cfg_ch.ready));
    case (idx)
      CfgMaxDist:  reg_max_dist  = 13'(value);
      CfgNumNeigh: reg_num_neigh = 4'(value);
      CfgAnchCnt:  reg_anch_cnt  = 7'(value);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    wait (pending_reqs.size() == 0 && expected_vel.size() == 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic set_regs(input int max_d, input int k, input int cnt);
    wait_idle();
    write_reg(CfgMaxDist, max_d);
    write_reg(CfgNumNeigh, k);
    write_reg(CfgAnchCnt, cnt);
  endtask

  function automatic int near_coord(input int c);
    int v;
    v = c + $urandom_range(2 * cl_r) - cl_r;
    return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
  endfunction

  task automatic push_load(input int idx, input int x, input int y,
                           input int vx, input int vy);
    req_t r;
    r.cmd = CmdLoad;
    r.anchor_index = 6'(idx);
    r.pos_x = 12'(x);
    r.pos_y = 12'(y);
    r.vel_x = 16'(vx);
    r.vel_y = 16'(vy);
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  task automatic push_query(input int x, input int y);
    req_t r;
    r = '0;
    r.anchor_index = 6'($urandom);
    r.vel_x = 16'($urandom);
    r.vel_y = 16'($urandom);
    r.cmd = CmdQuery;
    r.pos_x = 12'(x);
    r.pos_y = 12'(y);
    pending_reqs.insert(pending_reqs.size(), r);
  endtask

  // one random phase: mostly queries near the cluster, some reloads and far points
  task automatic random_phase(input int items);
    int a;
    for (int i = 0; i < items; i++) begin
      case ($urandom_range(9))
        0, 1: begin
          a = $urandom_range(NumAnchors - 1);
          push_load(a, near_coord(cl_x), near_coord(cl_y), $urandom, $urandom);
        end
        2: begin
          // exactly on an anchor, zero nearest distance when that anchor is scanned
          a = $urandom_range(NumAnchors - 1);
          push_query(tbl_px[a], tbl_py[a]);
        end
        3: push_query($urandom_range(4095), $urandom_range(4095));
        default: push_query(near_coord(cl_x), near_coord(cl_y));
      endcase
    end
  endtask

  task automatic new_cluster(input int radius);
    cl_x = $urandom_range(4095);
    cl_y = $urandom_range(4095);
    cl_r = radius;
  endtask

  initial begin
    int mode_idle [4];
    int mode_stall [4];
    int max_d, k, cnt;
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    rsp_ch.ready = 1'b0;
    err_cnt = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rsp_hold = 0;
    req_fired = 1'b0;
    quiet_cycles = 0;
    reg_max_dist = 13'd8191;
    reg_num_neigh = 4'd4;
    reg_anch_cnt = 7'd0;
    mode_idle  = '{0, 62, 0, 26};
    mode_stall = '{0, 0, 62, 26};
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty table under reset settings, then fill every entry
    push_query(0, 0);
    push_load(0, 0, 0, 32767, -32768);
    push_load(63, 4095, 4095, -32768, 32767);
    push_load(1, 0, 0, -32768, 32767);   // tie with entry 0
    push_load(2, 4095, 0, 1, -1);
    push_load(3, 0, 4095, 0, 0);
    new_cluster(40);
    for (int i = 4; i < 63; i++)
      push_load(i, near_coord(cl_x), near_coord(cl_y), $urandom, $urandom);
    set_regs(8191, 8, 64);
    push_query(0, 0);          // two anchors at zero distance, tie
    push_query(4095, 4095);
    push_query(4095, 0);
    push_query(2048, 2048);
    push_query(cl_x, cl_y);
    set_regs(0, 8, 64);        // only exact hits qualify
    push_query(0, 0);
    push_query(100, 100);
    set_regs(8191, 0, 64);     // no neighbours asked for
    push_query(0, 0);
    set_regs(8191, 1, 1);
    push_query(4095, 4095);

    // random phases over settings and idle modes
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin max_d = 8191; k = 8;  cnt = 64; end
        1: begin max_d = $urandom_range(1, 200); k = $urandom_range(1, 8);
                 cnt = $urandom_range(1, 64); end
        2: begin max_d = $urandom_range(8191); k = $urandom_range(8);
                 cnt = $urandom_range(16); end
        default: begin max_d = 50; k = 4; cnt = 64; end
      endcase
      set_regs(max_d, k, cnt);
      send_idle_pct  = mode_idle[ph % 4];
      recv_stall_pct = mode_stall[ph % 4];
      new_cluster($urandom_range(1) ? 60 : 600);
      if (ph == 2) rsp_hold = LongHold;   // block stalls its input meanwhile
      random_phase(70);
      // sender pauses until everything is back, then carries on
      wait (pending_reqs.size() == 0 && expected_vel.size() == 0);
      random_phase(70);
    end

    wait_idle();
    if (err_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/kvi_pkg.sv
sv/kvi_if.sv
sv/kvi_ram.sv
sv/kvi_divsqrt.sv
sv/knn_velocity_interpolator.sv
verif/tb_top.sv
